// ===== rtl/core/skt_pkg.sv =====
package skt_pkg;

  localparam int CAPACITY   = 16;
  localparam int NAME_CHARS = 8;

  localparam int KEY_W         = 32;
  localparam int NAME_W        = 64;
  localparam int AGE_W         = 8;
  localparam int ENTRY_COUNT_W = 5;
  localparam int CNT_W         = $clog2(CAPACITY + 1);

  localparam int S_DATA_W = 104;
  localparam int M_DATA_W = 112;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_DUMP   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [NAME_W-1:0]       name;
    logic [AGE_W-1:0]        age;
  } rec_t;

  // operation broadcast to every cell of the row
  typedef struct packed {
    logic ins;
    logic del;
    logic rot;
    rec_t new_rec;
  } cell_ctrl_t;

  // string copy of the packed name: keep bytes up to the first zero byte
  function automatic logic [NAME_W-1:0] clip_name(input logic [NAME_W-1:0] w);
    logic [NAME_W-1:0] r;
    logic              stop;
    r    = '0;
    stop = 1'b0;
    for (int i = 0; i < NAME_CHARS; i++) begin
      if (w[8*i +: 8] == 8'd0) begin
        stop = 1'b1;
      end
      if (!stop) begin
        r[8*i +: 8] = w[8*i +: 8];
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/skt_cell.sv =====
module skt_cell
  import skt_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       occupied,
  input  logic       left_lt,
  input  rec_t       left_rec,
  input  rec_t       right_rec,
  output rec_t       rec,
  output logic       lt
);

  // stored key below the key on the bus; along the sorted row this is a prefix
  always_comb begin
    lt = occupied && ($signed(rec.key) < $signed(ctrl.new_rec.key));
  end

  always_ff @(posedge clk) begin
    if (ctrl.ins && !lt) begin
      // first cell not below the key takes the new record, the rest move right
      rec <= left_lt ? ctrl.new_rec : left_rec;
    end else if (ctrl.del && !lt) begin
      rec <= right_rec;
    end else if (ctrl.rot) begin
      rec <= right_rec;
    end
  end

endmodule

// ===== rtl/core/sorted_key_table_core.sv =====
// channel | dir | beat contents
// s_*     | in  | tuser: cmd; tdata: key, name_word, age_value
// m_*     | out | tdata: ok .. is_empty; tlast: last result of the command
//
// insert, delete and clear each give one beat
// dump gives one beat per stored record (one beat when empty), one per cycle
// while m_tready holds; the row of cells rotates toward cell 0 to feed them
// rst clears the state, the record count and m_tvalid; cell contents and output data are not reset
// no new command is taken while a dump runs or while a result is stalled
module sorted_key_table_core
  import skt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [1:0]          s_tuser,   // cmd
  input  logic [S_DATA_W-1:0] s_tdata,   // key, name_word, age_value
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // ok, entry_valid, entry_key, entry_name,
                                         // entry_age, entry_count, is_empty
  output logic                m_tlast
);

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   rec_count;
  logic [CNT_W-1:0]   rec_count_next;
  logic [CNT_W-1:0]   dump_left;
  logic               out_ok;
  logic               out_entry_valid;
  rec_t               out_rec;
  logic               out_last;

  cmd_t               cmd;
  rec_t               in_rec;
  logic               out_free;
  logic               s_accept;
  logic               full;
  logic               found;
  logic               dump_hit;
  logic               do_ins;
  logic               do_del;
  logic               do_rot;
  cell_ctrl_t         ctrl;

  rec_t               cell_rec [CAPACITY];
  logic [CAPACITY-1:0] cell_lt;
  logic [CAPACITY-1:0] occupied;
  logic [CAPACITY-1:0] match;
  rec_t               left_in  [CAPACITY];
  rec_t               right_in [CAPACITY];
  logic [CAPACITY-1:0] left_lt_in;

  assign cmd          = cmd_t'(s_tuser);
  assign in_rec.key   = $signed(s_tdata[KEY_W-1:0]);
  assign in_rec.name  = clip_name(s_tdata[KEY_W +: NAME_W]);
  assign in_rec.age   = s_tdata[KEY_W+NAME_W +: AGE_W];

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign s_accept = s_tvalid && s_tready;
  assign full     = (rec_count == CNT_W'(CAPACITY));
  assign found    = |match;
  assign dump_hit = (cmd == CMD_DUMP) && (rec_count != '0);

  assign do_ins = s_accept && (cmd == CMD_INSERT) && !full;
  assign do_del = s_accept && (cmd == CMD_DELETE) && found;
  assign do_rot = out_free && (rec_count != '0) &&
                  (((state == ST_IDLE) && s_accept && (cmd == CMD_DUMP)) ||
                   (state == ST_DUMP));

  assign ctrl.ins     = do_ins;
  assign ctrl.del     = do_del;
  assign ctrl.rot     = do_rot;
  assign ctrl.new_rec = in_rec;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occupied[i]   = CNT_W'(i) < rec_count;
    assign match[i]      = occupied[i] && (cell_rec[i].key == in_rec.key);
    assign left_lt_in[i] = (i == 0) ? 1'b1 : cell_lt[(i == 0) ? 0 : i - 1];
    assign left_in[i]    = cell_rec[(i == 0) ? 0 : i - 1];
    // the last occupied cell wraps around to cell 0 during a dump
    assign right_in[i]   = ((i == CAPACITY - 1) || (CNT_W'(i + 1) == rec_count)) ?
                           cell_rec[0] : cell_rec[(i == CAPACITY - 1) ? 0 : i + 1];

    skt_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (occupied[i]),
      .left_lt   (left_lt_in[i]),
      .left_rec  (left_in[i]),
      .right_rec (right_in[i]),
      .rec       (cell_rec[i]),
      .lt        (cell_lt[i])
    );
  end

  always_comb begin
    rec_count_next = rec_count;
    if (s_accept) begin
      case (cmd)
        CMD_INSERT: if (!full) rec_count_next = rec_count + CNT_W'(1);
        CMD_DELETE: if (found) rec_count_next = rec_count - CNT_W'(1);
        CMD_CLEAR:  rec_count_next = '0;
        default:    rec_count_next = rec_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rec_count <= '0;
      dump_left <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      rec_count <= rec_count_next;
      case (state)
        ST_IDLE: begin
          if (s_accept) begin
            m_tvalid        <= 1'b1;
            out_ok          <= (cmd == CMD_INSERT) ? !full :
                               ((cmd == CMD_DELETE) ? found : 1'b1);
            out_entry_valid <= dump_hit;
            out_rec         <= dump_hit ? cell_rec[0] : '0;
            out_last        <= !dump_hit || (rec_count == CNT_W'(1));
            if (dump_hit) begin
              dump_left <= rec_count - CNT_W'(1);
              if (rec_count != CNT_W'(1)) begin
                state <= ST_DUMP;
              end
            end
          end else if (m_tready) begin
            m_tvalid <= 1'b0;
          end
        end
        ST_DUMP: begin
          if (out_free) begin
            m_tvalid        <= 1'b1;
            out_ok          <= 1'b1;
            out_entry_valid <= 1'b1;
            out_rec         <= cell_rec[0];
            out_last        <= (dump_left == CNT_W'(1));
            dump_left       <= dump_left - CNT_W'(1);
            if (dump_left == CNT_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state    <= ST_IDLE;
          m_tvalid <= 1'b0;
        end
      endcase
    end
  end

  assign m_tdata = {(rec_count == '0), ENTRY_COUNT_W'(rec_count), out_rec.age,
                    out_rec.name, out_rec.key, out_entry_valid, out_ok};
  assign m_tlast = out_last;

  a_no_take_in_dump: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DUMP) |-> !s_tready)
    else $error("command taken during dump");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rec_count <= CNT_W'(CAPACITY))
    else $error("record count above capacity");

  a_full_insert: assert property (@(posedge clk) disable iff (rst)
    (s_accept && (cmd == CMD_INSERT) && full) |=> full && !m_tdata[0])
    else $error("insert into full table changed it");

  a_dump_beat: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DUMP) && m_tvalid |-> out_entry_valid && !out_last)
    else $error("dump beat without record");

endmodule

// ===== verif/sorted_key_table_core_tb.sv =====
module sorted_key_table_core_tb;
  import skt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STUCK_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 90;

  typedef struct packed {
    logic                    ok;
    logic                    valid;
    logic signed [KEY_W-1:0] key;
    logic [NAME_W-1:0]       name;
    logic [AGE_W-1:0]        age;
    logic [ENTRY_COUNT_W-1:0] count;
    logic                    empty;
    logic                    last;
  } table_beat_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [1:0]          s_tuser = CMD_CLEAR;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic                m_tlast;

  // shadow copy of the table contents
  logic signed [KEY_W-1:0] tbl_key [CAPACITY];
  logic [NAME_W-1:0]       tbl_name [CAPACITY];
  logic [AGE_W-1:0]        tbl_age [CAPACITY];
  int                      tbl_count = 0;

  table_beat_t pending_beats[$];
  table_beat_t got_beat, want_beat;

  int  errors = 0;
  int  stuck = 0;
  int  stall_cnt = 0;
  bit  send_quiet = 1'b0;
  bit  recv_quiet = 1'b0;
  int  ins_done = 0, ins_refused = 0, del_done = 0, del_missed = 0;
  int  dumps_run = 0, clears_run = 0, beats_seen = 0;

  sorted_key_table_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #4 clk = ~clk;

  // mostly short gaps, a few long ones
  function automatic int pick_gap(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [NAME_W-1:0] string_copy(input logic [NAME_W-1:0] w);
    logic [NAME_W-1:0] r;
    r = '0;
    for (int i = 0; i < NAME_CHARS; i++) begin
      if (w[8*i +: 8] == 8'h00) break;
      r[8*i +: 8] = w[8*i +: 8];
    end
    return r;
  endfunction

  function automatic table_beat_t status_beat(input logic ok);
    table_beat_t b;
    b       = '0;
    b.ok    = ok;
    b.count = tbl_count[ENTRY_COUNT_W-1:0];
    b.empty = (tbl_count == 0);
    b.last  = 1'b1;
    return b;
  endfunction

  // update the shadow table and queue the beats this command must produce
  task automatic predict_table(input cmd_t cmd, input logic signed [KEY_W-1:0] key,
                               input logic [NAME_W-1:0] name, input logic [AGE_W-1:0] age);
    table_beat_t b;
    int          pos;
    logic        ok;
    ok = 1'b0;
    case (cmd)
      CMD_INSERT: begin
        if (tbl_count < CAPACITY) begin
          pos = 0;
          while (pos < tbl_count && tbl_key[pos] < key) pos++;
          for (int i = tbl_count; i > pos; i--) begin
            tbl_key[i]  = tbl_key[i-1];
            tbl_name[i] = tbl_name[i-1];
            tbl_age[i]  = tbl_age[i-1];
          end
          tbl_key[pos]  = key;
          tbl_name[pos] = string_copy(name);
          tbl_age[pos]  = age;
          tbl_count++;
          ok = 1'b1;
          ins_done++;
        end else begin
          ins_refused++;
        end
      end
      CMD_DELETE: begin
        pos = 0;
        while (pos < tbl_count && tbl_key[pos] != key) pos++;
        if (pos < tbl_count) begin
          for (int i = pos; i + 1 < tbl_count; i++) begin
            tbl_key[i]  = tbl_key[i+1];
            tbl_name[i] = tbl_name[i+1];
            tbl_age[i]  = tbl_age[i+1];
          end
          tbl_count--;
          ok = 1'b1;
          del_done++;
        end else begin
          del_missed++;
        end
      end
      CMD_CLEAR: begin
        tbl_count = 0;
        ok = 1'b1;
        clears_run++;
      end
      default: begin
        dumps_run++;
        if (tbl_count == 0) begin
          pending_beats.push_back(status_beat(1'b1));
        end else begin
          for (int i = 0; i < tbl_count; i++) begin
            b       = status_beat(1'b1);
            b.valid = 1'b1;
            b.key   = tbl_key[i];
            b.name  = tbl_name[i];
            b.age   = tbl_age[i];
            b.last  = (i + 1 == tbl_count);
            pending_beats.push_back(b);
          end
        end
        return;
      end
    endcase
    pending_beats.push_back(status_beat(ok));
  endtask

  // valid stays high from one beat to the next when there is no gap
  task automatic send_cmd(input cmd_t cmd, input logic signed [KEY_W-1:0] key,
                          input logic [NAME_W-1:0] name, input logic [AGE_W-1:0] age);
    int gap;
    gap = pick_gap(send_quiet);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {age, name, key};
    do @(posedge clk); while (!(s_tvalid && s_tready));
    predict_table(cmd, key, name, age);
  endtask

  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(0, 6) - 3;
    if (r < 50) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sh0;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [NAME_W-1:0] pick_name();
    logic [NAME_W-1:0] n;
    n = {$urandom, $urandom};
    if ($urandom_range(0, 9) < 4) n[8*$urandom_range(0, NAME_CHARS-1) +: 8] = 8'h00;
    return n;
  endfunction

  task automatic test_empty_table();
    send_cmd(CMD_DUMP, 32'sd0, '0, '0);
    send_cmd(CMD_DELETE, 32'sd5, '0, '0);
    send_cmd(CMD_CLEAR, 32'sd0, '0, '0);
    wait_all_results();
  endtask

  task automatic test_extreme_keys();
    send_cmd(CMD_INSERT, 32'sh7fff_ffff, 64'hffff_ffff_ffff_ffff, 8'hff);
    send_cmd(CMD_INSERT, 32'sh8000_0000, 64'h0, 8'h00);
    send_cmd(CMD_INSERT, 32'sd0, 64'h1122_3344_5500_6677, 8'h5a);
    send_cmd(CMD_INSERT, -32'sd1, 64'h4142_4344_4546_4700, 8'h01);
    // equal key goes in front of the older one
    send_cmd(CMD_INSERT, 32'sd0, 64'h0807_0605_0403_0201, 8'h80);
    send_cmd(CMD_DUMP, 32'sd0, '0, '0);
    send_cmd(CMD_DELETE, 32'sd0, '0, '0);
    send_cmd(CMD_DELETE, 32'sd12345, '0, '0);
    send_cmd(CMD_DUMP, 32'sd0, '0, '0);
    wait_all_results();
  endtask

  task automatic test_full_table();
    while (tbl_count < CAPACITY)
      send_cmd(CMD_INSERT, pick_key(), pick_name(), 8'($urandom));
    send_cmd(CMD_INSERT, 32'sd0, 64'h0000_0000_0000_0041, 8'h11);
    send_cmd(CMD_DUMP, 32'sd0, '0, '0);
    send_cmd(CMD_CLEAR, 32'sd0, '0, '0);
    wait_all_results();
  endtask

  task automatic test_random_mix();
    int r;
    logic signed [KEY_W-1:0] k;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 15 == 0) begin
        send_quiet = ($urandom_range(0, 3) == 0);
        recv_quiet = ($urandom_range(0, 3) == 0);
      end
      // let the block drain completely once mid-run
      if (n == RANDOM_ITEMS / 2) wait_all_results();
      r = $urandom_range(0, 99);
      if (r < 55) begin
        send_cmd(CMD_INSERT, pick_key(), pick_name(), 8'($urandom));
      end else if (r < 75) begin
        k = (r < 70 && tbl_count > 0) ? tbl_key[$urandom_range(0, tbl_count-1)] : pick_key();
        send_cmd(CMD_DELETE, k, {$urandom, $urandom}, 8'($urandom));
      end else if (r < 97) begin
        send_cmd(CMD_DUMP, $urandom, {$urandom, $urandom}, 8'($urandom));
      end else begin
        send_cmd(CMD_CLEAR, $urandom, {$urandom, $urandom}, 8'($urandom));
      end
    end
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
    wait_all_results();
  endtask

  always @(posedge clk) begin
    if (stall_cnt > 0) begin
      m_tready  <= 1'b0;
      stall_cnt <= stall_cnt - 1;
    end else begin
      m_tready  <= 1'b1;
      stall_cnt <= pick_gap(recv_quiet);
    end
  end

  task automatic compare_field(input string fld, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 40)
        $display("%0t: %s mismatch, expected %h, got %h", $time, fld, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      beats_seen++;
      got_beat.ok    = m_tdata[0];
      got_beat.valid = m_tdata[1];
      got_beat.key   = m_tdata[33:2];
      got_beat.name  = m_tdata[97:34];
      got_beat.age   = m_tdata[105:98];
      got_beat.count = m_tdata[110:106];
      got_beat.empty = m_tdata[111];
      got_beat.last  = m_tlast;
      if (pending_beats.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: beat with nothing expected, expected none, got %h", $time, m_tdata);
      end else begin
        want_beat = pending_beats.pop_front();
        compare_field("ok", 64'(want_beat.ok), 64'(got_beat.ok));
        compare_field("entry_valid", 64'(want_beat.valid), 64'(got_beat.valid));
        compare_field("entry_key", 64'(want_beat.key), 64'(got_beat.key));
        compare_field("entry_name", want_beat.name, got_beat.name);
        compare_field("entry_age", 64'(want_beat.age), 64'(got_beat.age));
        compare_field("entry_count", 64'(want_beat.count), 64'(got_beat.count));
        compare_field("is_empty", 64'(want_beat.empty), 64'(got_beat.empty));
        compare_field("last", 64'(want_beat.last), 64'(got_beat.last));
      end
    end
  end

  // nothing moving on either side for too long means the block hung
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck = 0;
    end else begin
      stuck = stuck + 1;
    end
    if (stuck == STUCK_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
               $time, STUCK_LIMIT, pending_beats.size());
      $display("sorted_key_table_core regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_extreme_keys();
    test_full_table();
    test_random_mix();
    repeat (20) @(posedge clk);
    $display("inserts %0d (refused when full %0d), deletes %0d (no match %0d)",
             ins_done, ins_refused, del_done, del_missed);
    $display("dumps %0d, clears %0d, result beats checked %0d",
             dumps_run, clears_run, beats_seen);
    if (errors == 0 && pending_beats.size() == 0) begin
      $display("sorted_key_table_core regression: pass");
    end else begin
      $display("sorted_key_table_core regression: fail");
    end
    $finish;
  end

endmodule
